// ----- hw/rtl/dbiv_pkg.sv -----
// Package for the dual-bank image validator.
// Holds payload structs, header layout constants, register indexes and the CRC step.
// No dependencies.
package dbiv_pkg;

    localparam int POS_W     = 17;
    localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
    localparam logic [POS_W-1:0] HDR_BYTES = 17'd12;

    localparam logic [POS_W-1:0] POS_SEQ_LO = 17'd6;
    localparam logic [POS_W-1:0] POS_SEQ_HI = 17'd7;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd8;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd9;
    localparam logic [POS_W-1:0] POS_CRC_LO = 17'd10;
    localparam logic [POS_W-1:0] POS_CRC_HI = 17'd11;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [31:0] MAGIC_RESET  = 32'h534C564D;
    localparam logic [15:0] MAXLEN_RESET = 16'd2036;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MAGIC     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LENGTH = 1'd1;

    typedef enum logic [2:0] {
        CAUSE_OK        = 3'd0,
        CAUSE_BAD_MAGIC = 3'd1,
        CAUSE_TOO_LONG  = 3'd2,
        CAUSE_SHORT     = 3'd3,
        CAUSE_CRC       = 3'd4
    } fail_cause_t;

    typedef struct packed {
        logic       bank_select;
        logic [7:0] image_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic        checked_bank;
        logic        bank_ok;
        logic [2:0]  fail_cause;
        logic [15:0] computed_crc;
        logic        chosen_bank;
    } out_item_t;

    // verdict of the image parser, handed to the bank selector
    typedef struct packed {
        logic        bank;
        logic        ok;
        fail_cause_t cause;
        logic [15:0] crc;
        logic [15:0] sequence_num;
    } verdict_t;

    // reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/dbiv_image_check.sv -----
// Header capture, payload CRC and verdict for one bank image.
// Holds the config registers. Depends on dbiv_pkg.
module dbiv_image_check
    import dbiv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_advance,
    input  in_item_t              item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output verdict_t              verdict
);

    logic [31:0]      magic_cfg_reg;
    logic [15:0]      maxlen_cfg_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      magic_reg, magic_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      hcrc_reg, hcrc_next;
    logic [15:0]      crc_reg, crc_next;
    logic [POS_W-1:0] pay_cnt;
    fail_cause_t      cause;

    always_comb begin
        magic_next = magic_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        hcrc_next  = hcrc_reg;
        crc_next   = crc_reg;
        if (pos_reg < 17'd4) begin
            magic_next[8*pos_reg[1:0] +: 8] = item.image_byte;
        end else if (pos_reg == POS_SEQ_LO) begin
            seq_next[7:0] = item.image_byte;
        end else if (pos_reg == POS_SEQ_HI) begin
            seq_next[15:8] = item.image_byte;
        end else if (pos_reg == POS_LEN_LO) begin
            len_next[7:0] = item.image_byte;
        end else if (pos_reg == POS_LEN_HI) begin
            len_next[15:8] = item.image_byte;
        end else if (pos_reg == POS_CRC_LO) begin
            hcrc_next[7:0] = item.image_byte;
        end else if (pos_reg == POS_CRC_HI) begin
            hcrc_next[15:8] = item.image_byte;
        end else if (pos_reg >= HDR_BYTES &&
                     (pos_reg - HDR_BYTES) < {1'b0, len_reg}) begin
            crc_next = crc16_byte(crc_reg, item.image_byte);
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 17'd1 : pos_reg;
    end

    // pos_next counts the bytes seen including this one
    assign pay_cnt = pos_next - HDR_BYTES;

    always_comb begin
        if (pos_next < HDR_BYTES) begin
            cause = CAUSE_SHORT;
        end else if (magic_next != magic_cfg_reg) begin
            cause = CAUSE_BAD_MAGIC;
        end else if (len_next > maxlen_cfg_reg) begin
            cause = CAUSE_TOO_LONG;
        end else if (pay_cnt < {1'b0, len_next}) begin
            cause = CAUSE_SHORT;
        end else if (len_next != 16'd0 && crc_next != hcrc_next) begin
            cause = CAUSE_CRC;
        end else begin
            cause = CAUSE_OK;
        end
    end

    assign verdict.bank         = item.bank_select;
    assign verdict.ok           = (cause == CAUSE_OK);
    assign verdict.cause        = cause;
    assign verdict.crc          = crc_next;
    assign verdict.sequence_num = seq_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_cfg_reg  <= MAGIC_RESET;
            maxlen_cfg_reg <= MAXLEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_EXPECTED_MAGIC:     magic_cfg_reg  <= cfg_wdata;
                CFG_MAX_PAYLOAD_LENGTH: maxlen_cfg_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            magic_reg <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            hcrc_reg  <= '0;
            crc_reg   <= CRC_INIT;
        end else if (item_advance) begin
            if (item.final_byte) begin
                pos_reg   <= '0;
                magic_reg <= '0;
                seq_reg   <= '0;
                len_reg   <= '0;
                hcrc_reg  <= '0;
                crc_reg   <= CRC_INIT;
            end else begin
                pos_reg   <= pos_next;
                magic_reg <= magic_next;
                seq_reg   <= seq_next;
                len_reg   <= len_next;
                hcrc_reg  <= hcrc_next;
                crc_reg   <= crc_next;
            end
        end
    end

endmodule

// ----- hw/rtl/dbiv_bank_sel.sv -----
// Per-bank valid flags and sequences, active bank choice.
// Depends on dbiv_pkg.
module dbiv_bank_sel
    import dbiv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     verdict_fire,
    input  verdict_t verdict,
    output logic     chosen_bank
);

    logic [1:0]  valid_reg, valid_next;
    logic [15:0] seq_a_reg, seq_a_next;
    logic [15:0] seq_b_reg, seq_b_next;
    logic [15:0] diff;

    always_comb begin
        valid_next = valid_reg;
        seq_a_next = seq_a_reg;
        seq_b_next = seq_b_reg;
        valid_next[verdict.bank] = verdict.ok;
        if (verdict.ok) begin
            if (verdict.bank) begin
                seq_b_next = verdict.sequence_num;
            end else begin
                seq_a_next = verdict.sequence_num;
            end
        end
        diff = seq_a_next - seq_b_next;
        if (valid_next[0] && valid_next[1]) begin
            // A wins only when strictly newer by wrapping difference
            chosen_bank = !(diff != 16'd0 && !diff[15]);
        end else begin
            chosen_bank = !valid_next[0] && valid_next[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            seq_a_reg <= '0;
            seq_b_reg <= '0;
        end else if (verdict_fire) begin
            valid_reg <= valid_next;
            seq_a_reg <= seq_a_next;
            seq_b_reg <= seq_b_next;
        end
    end

endmodule

// ----- hw/rtl/dual_bank_image_validator_top.sv -----
// Top level of the dual-bank image validator: input register, checker, bank
// selector and result register. Depends on dbiv_pkg, dbiv_image_check, dbiv_bank_sel.
//
//  channel  ports                    moves
//  input    s_valid/s_ready/s_item   one image byte per request
//  result   m_valid/m_ready/m_item   one verdict per final byte
//  config   cfg_wr_en/index/wdata    register write, no wait
//
// One byte per cycle while no final byte stalls; each byte is held in the input
// register, and a final byte's verdict is then registered in the result register.
// The CRC update, header capture and verdict are combinational logic between the two.
// A final byte stalls in the input register only while the result register
// holds an untaken verdict, and the input channel waits behind it; no other
// byte stalls. Reset is synchronous, active low, clears all image state and
// bank flags, and returns the config registers to their defaults.
module dual_bank_image_validator_top
    import dbiv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      out_free;
    logic      advance;
    logic      fire;
    verdict_t  verdict;
    logic      chosen;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_item_reg.final_byte || out_free);
    assign fire     = advance && in_item_reg.final_byte;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    dbiv_image_check u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_advance (advance),
        .item         (in_item_reg),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .verdict      (verdict)
    );

    dbiv_bank_sel u_sel (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .verdict_fire (fire),
        .verdict      (verdict),
        .chosen_bank  (chosen)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg.checked_bank <= verdict.bank;
            out_item_reg.bank_ok      <= verdict.ok;
            out_item_reg.fail_cause   <= verdict.cause;
            out_item_reg.computed_crc <= verdict.crc;
            out_item_reg.chosen_bank  <= chosen;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // input side stalls only behind an untaken verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && in_item_reg.final_byte))
        else $error("input stalled without a pending verdict");

    // a final byte that leaves the input register yields a verdict next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("verdict lost");

    // a taken verdict is not repeated unless a new final byte fired
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !fire) |=> !m_valid)
        else $error("verdict repeated");

endmodule

// ----- bench/dbiv_verdict_checker.sv -----
// Bench-side CRC helper and the verdict checker for the dual-bank image validator.
// The checker follows both channels and the register port, predicts each bank verdict
// and compares it with what the block delivers. Depends on dbiv_pkg.
package dbiv_bench_pkg;

    import dbiv_pkg::*;

    // reflected CRC-16, one byte, bit by bit from the LSB
    function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                      input logic [7:0]  data);
        logic [15:0] r;
        r = crc ^ {8'h00, data};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

module dbiv_verdict_checker
    import dbiv_pkg::*;
    import dbiv_bench_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    verdicts_pending,
    output int                    verdicts_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]      magic_reg;
    logic [15:0]      maxlen_reg;

    logic [POS_W-1:0] byte_pos;
    logic [31:0]      hdr_magic;
    logic [15:0]      hdr_seq;
    logic [15:0]      hdr_len;
    logic [15:0]      hdr_crc;
    logic [15:0]      payload_crc;
    logic             bank_good [2];
    logic [15:0]      bank_seq  [2];

    out_item_t        verdict_q [$];

    task automatic clear_image();
        byte_pos    = '0;
        hdr_magic   = '0;
        hdr_seq     = '0;
        hdr_len     = '0;
        hdr_crc     = '0;
        payload_crc = CRC_INIT;
    endtask

    task automatic absorb_byte(input in_item_t req);
        logic [POS_W-1:0] pos;
        fail_cause_t      cause;
        logic [15:0]      seq_gap;
        out_item_t        v;
        pos = byte_pos;
        if (pos < 4) begin
            hdr_magic[pos[1:0]*8 +: 8] = req.image_byte;
        end else if (pos == POS_SEQ_LO) begin
            hdr_seq[7:0] = req.image_byte;
        end else if (pos == POS_SEQ_HI) begin
            hdr_seq[15:8] = req.image_byte;
        end else if (pos == POS_LEN_LO) begin
            hdr_len[7:0] = req.image_byte;
        end else if (pos == POS_LEN_HI) begin
            hdr_len[15:8] = req.image_byte;
        end else if (pos == POS_CRC_LO) begin
            hdr_crc[7:0] = req.image_byte;
        end else if (pos == POS_CRC_HI) begin
            hdr_crc[15:8] = req.image_byte;
        end else if (pos >= HDR_BYTES && (pos - HDR_BYTES) < {1'b0, hdr_len}) begin
            payload_crc = modbus_crc_update(payload_crc, req.image_byte);
        end
        if (byte_pos != POS_MAX) begin
            byte_pos = byte_pos + 1'b1;
        end
        if (!req.final_byte) begin
            return;
        end

        if (byte_pos < HDR_BYTES) begin
            cause = CAUSE_SHORT;
        end else if (hdr_magic != magic_reg) begin
            cause = CAUSE_BAD_MAGIC;
        end else if (hdr_len > maxlen_reg) begin
            cause = CAUSE_TOO_LONG;
        end else if ((byte_pos - HDR_BYTES) < {1'b0, hdr_len}) begin
            cause = CAUSE_SHORT;
        end else if (hdr_len != 16'd0 && payload_crc != hdr_crc) begin
            cause = CAUSE_CRC;
        end else begin
            cause = CAUSE_OK;
        end

        // a failed bank keeps its old sequence, only the flag drops
        bank_good[req.bank_select] = (cause == CAUSE_OK);
        if (cause == CAUSE_OK) begin
            bank_seq[req.bank_select] = hdr_seq;
        end

        seq_gap = bank_seq[0] - bank_seq[1];
        if (bank_good[0] && bank_good[1]) begin
            v.chosen_bank = !(seq_gap != 16'd0 && !seq_gap[15]);
        end else if (bank_good[0]) begin
            v.chosen_bank = 1'b0;
        end else if (bank_good[1]) begin
            v.chosen_bank = 1'b1;
        end else begin
            v.chosen_bank = 1'b0;
        end
        v.checked_bank = req.bank_select;
        v.bank_ok      = (cause == CAUSE_OK);
        v.fail_cause   = cause;
        v.computed_crc = payload_crc;
        verdict_q.push_back(v);
        clear_image();
    endtask

    task automatic check_verdict(input out_item_t got);
        out_item_t want;
        logic      bad;
        if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected verdict: bank %0d ok %0b cause %0d crc %04h chosen %0d",
                         got.checked_bank, got.bank_ok, got.fail_cause, got.computed_crc,
                         got.chosen_bank);
            end
            return;
        end
        want = verdict_q.pop_front();
        verdicts_checked++;
        bad = (got.checked_bank !== want.checked_bank) || (got.bank_ok !== want.bank_ok) ||
              (got.fail_cause !== want.fail_cause) ||
              (got.computed_crc !== want.computed_crc) ||
              (got.chosen_bank !== want.chosen_bank);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("verdict mismatch: want bank %0d ok %0b cause %0d crc %04h chosen %0d",
                         want.checked_bank, want.bank_ok, want.fail_cause,
                         want.computed_crc, want.chosen_bank);
                $display("                  got  bank %0d ok %0b cause %0d crc %04h chosen %0d",
                         got.checked_bank, got.bank_ok, got.fail_cause, got.computed_crc,
                         got.chosen_bank);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg  = MAGIC_RESET;
            maxlen_reg = MAXLEN_RESET;
            clear_image();
            bank_good  = '{1'b0, 1'b0};
            bank_seq   = '{16'd0, 16'd0};
            verdict_q.delete();
            mismatches       = 0;
            verdicts_checked = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_EXPECTED_MAGIC:     magic_reg  = cfg_wdata;
                    CFG_MAX_PAYLOAD_LENGTH: maxlen_reg = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // the result side first: a verdict never leaves on the edge its byte enters
            if (m_valid && m_ready) begin
                check_verdict(m_item);
            end
            if (s_valid && s_ready) begin
                absorb_byte(s_item);
            end
        end
        verdicts_pending <= verdict_q.size();
    end

endmodule

// ----- bench/tb_dual_bank_image_validator_top.sv -----
// Stimulus and verdict for the dual-bank image validator.
// Streams bank images through five idling and register phases; checking sits in
// dbiv_verdict_checker. Depends on dbiv_pkg, dbiv_bench_pkg and the block itself.
module tb_dual_bank_image_validator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dbiv_pkg::*;
    import dbiv_bench_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_GAP   = 8;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int verdicts_pending;
    int verdicts_checked;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent     = 0;
    int          images_sent    = 0;
    int          cycle_count    = 0;
    logic [31:0] cur_magic      = MAGIC_RESET;
    logic [15:0] cur_maxlen     = MAXLEN_RESET;
    logic [15:0] last_seq [2]   = '{16'd0, 16'd0};

    int send_idle_by_phase  [5] = '{0, 60, 0, 34, 0};
    int recv_stall_by_phase [5] = '{0, 0, 60, 34, 0};

    dual_bank_image_validator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dbiv_verdict_checker verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_item           (s_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_item           (m_item),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdicts_pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one request on the input channel, with a random gap ahead of it
    task automatic send_byte(input logic bank, input logic [7:0] data, input logic fin);
        in_item_t req;
        req.bank_select = bank;
        req.image_byte  = data;
        req.final_byte  = fin;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        @(posedge aclk iff s_ready);
        bytes_sent++;
    endtask

    // header_n below 12 cuts the image inside the header
    task automatic send_image(input logic bank, input logic [31:0] magic,
                              input logic [15:0] seq, input logic [15:0] len,
                              input int payload_n, input int extra_n,
                              input logic crc_good, input int header_n);
        logic [7:0]  image_q   [$];
        logic [7:0]  payload_q [$];
        logic [7:0]  head      [12];
        logic [7:0]  data;
        logic [15:0] crc;
        int          i;
        crc = CRC_INIT;
        for (i = 0; i < payload_n; i++) begin
            data = 8'($urandom);
            payload_q.push_back(data);
            if (i < len) begin
                crc = modbus_crc_update(crc, data);
            end
        end
        if (!crc_good) begin
            crc = crc ^ (16'h1 << $urandom_range(15));
        end
        head = '{magic[7:0], magic[15:8], magic[23:16], magic[31:24],
                 8'($urandom), 8'($urandom), seq[7:0], seq[15:8],
                 len[7:0], len[15:8], crc[7:0], crc[15:8]};
        for (i = 0; i < header_n; i++) begin
            image_q.push_back(head[i]);
        end
        if (header_n == 12) begin
            image_q = {image_q, payload_q};
            for (i = 0; i < extra_n; i++) begin
                image_q.push_back(8'($urandom));
            end
        end
        // only the final byte's bank select counts, the rest may wander
        for (i = 0; i < image_q.size(); i++) begin
            if (i == image_q.size() - 1) begin
                send_byte(bank, image_q[i], 1'b1);
            end else begin
                send_byte(1'($urandom), image_q[i], 1'b0);
            end
        end
        last_seq[bank] = seq;
        images_sent++;
    endtask

    // sequences clustered around the other bank's and the wrap points
    function automatic logic [15:0] pick_seq(input logic bank);
        logic [15:0] other;
        other = last_seq[~bank];
        case ($urandom_range(5))
            0:       return other;
            1:       return other + 16'd1;
            2:       return other - 16'd1;
            3:       return other ^ 16'h8000;
            4:       return $urandom_range(1) ? 16'h7FFF : 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_image();
        logic        bank;
        logic [15:0] seq;
        logic [15:0] len;
        logic [15:0] len1;
        int          cap;
        int          extra;
        int          roll;
        int          over;
        int          n;
        int          i;
        bank  = 1'($urandom_range(1));
        seq   = pick_seq(bank);
        cap   = (cur_maxlen < 12) ? int'(cur_maxlen) : 12;
        len   = 16'($urandom_range(cap));
        len1  = (len == 16'd0) ? 16'd1 : len;
        extra = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
        roll  = $urandom_range(99);
        if (roll < 55) begin
            send_image(bank, cur_magic, seq, len, len, extra, 1'b1, 12);
        end else if (roll < 63) begin
            send_image(bank, cur_magic, seq, len1, len1, extra, 1'b0, 12);
        end else if (roll < 70) begin
            send_image(bank, cur_magic ^ (32'h1 << $urandom_range(31)), seq, len, len,
                       extra, 1'b1, 12);
        end else if (roll < 76) begin
            over = int'(cur_maxlen) + $urandom_range(4, 1);
            if (over > 65535) begin
                over = 65535;
            end
            send_image(bank, cur_magic, seq, 16'(over), $urandom_range(4), 0, 1'b1, 12);
        end else if (roll < 84) begin
            send_image(bank, cur_magic, seq, len1, $urandom_range(int'(len1) - 1), 0,
                       1'b1, 12);
        end else if (roll < 90) begin
            send_image(bank, cur_magic, seq, len, 0, 0, 1'b1, $urandom_range(11, 1));
        end else begin
            // loose bytes with scattered final marks
            n = $urandom_range(20, 1);
            for (i = 0; i < n; i++) begin
                send_byte(1'($urandom), 8'($urandom),
                          (i == n - 1) || ($urandom_range(7) == 0));
            end
            images_sent++;
        end
    endtask

    // lets every verdict out, then idles for the block to settle
    task automatic drain_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [31:0] magic, input logic [15:0] maxlen);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_EXPECTED_MAGIC;
        cfg_wdata <= magic;
        @(posedge aclk);
        cfg_index <= CFG_MAX_PAYLOAD_LENGTH;
        cfg_wdata <= {16'h0000, maxlen};
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cur_magic  = magic;
        cur_maxlen = maxlen;
    endtask

    initial begin
        int phase;
        int start_bytes;
        int start_images;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < 5; phase++) begin
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            if (phase > 0) begin
                drain_verdicts();
            end
            case (phase)
                1: write_limits(32'h0000_0000, 16'h0000);
                2: write_limits(32'hFFFF_FFFF, MAXLEN_RESET);
                3: write_limits($urandom, 16'($urandom_range(300, 16)));
                4: write_limits(MAGIC_RESET, 16'hFFFF);
                default: ;
            endcase

            if (phase == 0) begin
                // reset register values; truncation, zero length, wrap and tie picks
                send_image(1'b1, cur_magic, 16'h0000, 16'd0, 0, 0, 1'b1, 1);
                send_image(1'b0, cur_magic, 16'hFFFF, 16'd0, 0, 0, 1'b0, 12);
                send_image(1'b1, cur_magic, 16'h0001, 16'd1, 1, 2, 1'b1, 12);
                send_image(1'b0, cur_magic, 16'h0001, 16'd3, 3, 0, 1'b0, 12);
                send_image(1'b1, cur_magic ^ 32'h8000_0000, 16'h0002, 16'd0, 0, 0, 1'b1, 12);
                send_image(1'b0, cur_magic, 16'h8001, 16'hFFFF, 2, 0, 1'b1, 12);
                send_image(1'b0, cur_magic, 16'h8001, 16'd4, 2, 0, 1'b1, 12);
                send_image(1'b1, cur_magic, 16'h0001, 16'd0, 0, 0, 1'b1, 12);
                send_image(1'b0, cur_magic, 16'h8001, 16'd0, 0, 0, 1'b1, 12);
                send_image(1'b0, cur_magic, 16'h0001, 16'd2, 2, 0, 1'b1, 12);
                send_image(1'b1, cur_magic, 16'h0003, 16'd0, 0, 0, 1'b1, 11);
            end else if (phase == 4) begin
                // a payload well past the random lengths, with trailing bytes after it
                send_image(1'b1, cur_magic, pick_seq(1'b1), 16'd64, 64, 8, 1'b1, 12);
            end

            start_bytes  = bytes_sent;
            start_images = images_sent;
            while (bytes_sent - start_bytes < 100 || images_sent - start_images < 6) begin
                random_image();
            end
        end

        drain_verdicts();
        $display("Sent %0d image bytes in %0d images; %0d bank verdicts checked over five",
                 bytes_sent, images_sent, verdicts_checked);
        $display("phases of sender gaps, receiver stalls and magic/length register settings.");
        if (mismatches == 0 && verdicts_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
